@@ hdl/fdms_pkg.sv @@
// Shared constants and sizes for the frame-difference motion salience block.
`timescale 1ns / 1ps

package fdms_pkg;

   // Frame ring geometry
   localparam int FRAME_PIXELS = 16384;
   localparam int MAX_GAP      = 7;
   localparam int SLOTS        = MAX_GAP + 1;
   localparam int POS_W        = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
   localparam int SLOT_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int ADDR_W       = SLOT_W + POS_W;
   localparam int STORE_DEPTH  = 1 << ADDR_W;

   // Field widths
   localparam int CHAN_W   = 8;
   localparam int PIX_W    = 3 * CHAN_W;
   localparam int GAP_W    = 3;
   localparam int SQ_W     = 2 * CHAN_W;
   localparam int DIST_W   = SQ_W + 2;
   localparam int SAL_W    = 12;
   localparam int SHADE_W  = 8;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 32;

   localparam logic [GAP_W-1:0] GAP_RESET = 3'd5;

   // Output limits
   localparam logic [SAL_W-1:0]   SAL_MAX   = 12'd2550;
   localparam logic [SHADE_W-1:0] SHADE_MAX = 8'd255;
   localparam logic [DIST_W-1:0]  RED_SAT   = 18'd2560; // dist/10 >= 256 from here

   // floor(d/10) == (d * 6554) >> 16 exact for d below 16384
   localparam int RECIP_W     = 13;
   localparam logic [RECIP_W-1:0] RECIP_TEN = 13'd6554;
   localparam int RECIP_SHIFT = 16;
   localparam int PROD_W      = SAL_W + RECIP_W;

endpackage

@@ hdl/fdms_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module fdms_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 131072
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/frame_difference_motion_salience_top.sv @@
// Top level of the frame-difference motion salience block.
`timescale 1ns / 1ps

// Takes one RGB pixel per clock while req_tready is high, in raster order, and compares
// it with the pixel at the same position gap frames back (or the first frame of the run
// until gap frames exist). Throughput is one pixel per cycle while results are taken:
// each beat does one read and one write of the frame ring memory, which has a separate
// read and write port. A beat passes three register stages (memory read, squared
// differences, saturation and divide by ten). A stalled result holds its stage, the
// stages behind it fill, and req_tready drops in the same cycle once all three are full.
// Memory is not cleared after reset; reads of unwritten reference positions go unchecked.
// Write gap only while idle; any write restarts the frame count.
module frame_difference_motion_salience_top
   import fdms_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,  // red_in[7:0], green_in[15:8], blue_in[23:16]
   input  logic                   req_tlast,  // frame_end
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,  // salience_tenths[11:0], shade_red[19:12],
                                              // shade_green[27:20], zero pad [31:28]
   output logic                   rsp_tlast,  // last_of_frame
   input  logic                   csr_wr_en,
   input  logic [GAP_W-1:0]       csr_wr_data // gap
);

   // control state
   logic [GAP_W-1:0]  gap_ff, gap_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [SLOT_W-1:0] wslot_ff, wslot_in;
   logic [SLOT_W-1:0] held_ff, held_in;

   // pipeline valids
   logic a_valid_ff, b_valid_ff, c_valid_ff;
   logic en_a, en_b, en_c, accept;

   // stage A: memory read in flight
   logic [PIX_W-1:0] a_pix_ff;
   logic             a_last_ff, a_same_ff;
   logic [PIX_W-1:0] ref_pix;

   // stage B: squared channel differences
   logic [SQ_W-1:0] b_sq_ff [3];
   logic [SQ_W-1:0] b_sq_in [3];
   logic            b_last_ff;

   // stage C: results
   logic [SAL_W-1:0]   c_sal_ff, c_sal_in;
   logic [SHADE_W-1:0] c_red_ff, c_red_in, c_green_ff, c_green_in;
   logic               c_last_ff;

   logic [PIX_W-1:0]  cur_pix;
   logic [SLOT_W-1:0] eff_gap, held_now, ref_slot;
   logic [DIST_W-1:0] distance;
   logic [PROD_W-1:0] tenth_prod;

   assign en_c   = !c_valid_ff || rsp_tready;
   assign en_b   = !b_valid_ff || en_c;
   assign en_a   = !a_valid_ff || en_b;
   assign accept = req_tvalid && en_a;
   assign req_tready = en_a;

   // stored as red[23:16], green[15:8], blue[7:0]
   assign cur_pix = {req_tdata[7:0], req_tdata[15:8], req_tdata[23:16]};

   always_comb begin
      eff_gap  = (int'(gap_ff) > MAX_GAP) ? SLOT_W'(MAX_GAP) : SLOT_W'(gap_ff);
      held_now = (held_ff > eff_gap) ? eff_gap : held_ff;
      if (wslot_ff >= held_now) begin
         ref_slot = wslot_ff - held_now;
      end else begin
         ref_slot = SLOT_W'(int'(wslot_ff) + SLOTS - int'(held_now));
      end

      gap_in   = gap_ff;
      pos_in   = pos_ff;
      wslot_in = wslot_ff;
      held_in  = held_ff;
      if (accept) begin
         held_in = held_now;
         if (req_tlast) begin
            pos_in   = '0;
            wslot_in = (int'(wslot_ff) == SLOTS - 1) ? '0 : wslot_ff + 1'b1;
            if (held_now < eff_gap) begin
               held_in = held_now + 1'b1;
            end
         end else begin
            pos_in = (int'(pos_ff) == FRAME_PIXELS - 1) ? '0 : pos_ff + 1'b1;
         end
      end
      if (csr_wr_en) begin
         gap_in  = csr_wr_data;
         held_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff   <= GAP_RESET;
         pos_ff   <= '0;
         wslot_ff <= '0;
         held_ff  <= '0;
      end else begin
         gap_ff   <= gap_in;
         pos_ff   <= pos_in;
         wslot_ff <= wslot_in;
         held_ff  <= held_in;
      end
   end

   fdms_ram #(
      .WIDTH (PIX_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr ({wslot_ff, pos_ff}),
      .wr_data (cur_pix),
      .rd_en   (en_a),
      .rd_addr ({ref_slot, pos_ff}),
      .rd_data (ref_pix)
   );

   // valids
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         if (en_a) a_valid_ff <= req_tvalid;
         if (en_b) b_valid_ff <= a_valid_ff;
         if (en_c) c_valid_ff <= b_valid_ff;
      end
   end

   // ref_slot equals wslot only when held_now is 0, masked via a_same_ff: no forwarding needed.
   always_ff @(posedge clock) begin
      if (en_a) begin
         a_pix_ff  <= cur_pix;
         a_last_ff <= req_tlast;
         a_same_ff <= (held_now == '0);
      end
   end

   always_comb begin
      logic [CHAN_W-1:0] cur_c, ref_c, diff;
      for (int i = 0; i < 3; i++) begin
         cur_c = a_pix_ff[i*CHAN_W +: CHAN_W];
         ref_c = ref_pix[i*CHAN_W +: CHAN_W];
         diff  = (cur_c > ref_c) ? cur_c - ref_c : ref_c - cur_c;
         b_sq_in[i] = a_same_ff ? '0 : SQ_W'(diff) * SQ_W'(diff);
      end
   end

   always_ff @(posedge clock) begin
      if (en_b) begin
         b_sq_ff   <= b_sq_in;
         b_last_ff <= a_last_ff;
      end
   end

   always_comb begin
      distance   = DIST_W'(b_sq_ff[0]) + DIST_W'(b_sq_ff[1]) + DIST_W'(b_sq_ff[2]);
      tenth_prod = PROD_W'(distance[SAL_W-1:0]) * PROD_W'(RECIP_TEN);
      c_sal_in   = (distance > DIST_W'(SAL_MAX)) ? SAL_MAX : distance[SAL_W-1:0];
      c_green_in = (distance > DIST_W'(SHADE_MAX)) ? SHADE_MAX : distance[SHADE_W-1:0];
      c_red_in   = (distance >= RED_SAT) ? SHADE_MAX
                                         : tenth_prod[RECIP_SHIFT +: SHADE_W];
   end

   always_ff @(posedge clock) begin
      if (en_c) begin
         c_sal_ff   <= c_sal_in;
         c_red_ff   <= c_red_in;
         c_green_ff <= c_green_in;
         c_last_ff  <= b_last_ff;
      end
   end

   assign rsp_tvalid = c_valid_ff;
   assign rsp_tlast  = c_last_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - SAL_W - 2 * SHADE_W){1'b0}},
                        c_green_ff, c_red_ff, c_sal_ff};

endmodule

@@ hdl/fdms_checker.sv @@
// Port-level assertions for the motion salience top level, with its bind.
`timescale 1ns / 1ps

module fdms_checker
   import fdms_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tlast
);

   logic [SAL_W-1:0]   sal;
   logic [SHADE_W-1:0] red, green;

   assign sal   = rsp_tdata[SAL_W-1:0];
   assign red   = rsp_tdata[SAL_W +: SHADE_W];
   assign green = rsp_tdata[SAL_W + SHADE_W +: SHADE_W];

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result beat changed while stalled");

   // empty pipeline after reset: nothing to send, ready to take a pixel
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid && req_tready)
      else $error("pipeline not empty right after reset");

   a_sal_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> sal <= SAL_MAX)
      else $error("salience above saturation");

   // small distances: green shade equals the distance itself
   a_green_match: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && sal < SAL_W'(SHADE_MAX) |-> green == SHADE_W'(sal))
      else $error("green shade disagrees with salience");

   a_red_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && red == SHADE_MAX |-> sal == SAL_MAX && green == SHADE_MAX)
      else $error("red shade saturated without salience saturation");

endmodule

bind frame_difference_motion_salience_top fdms_checker u_fdms_checker (.*);

@@ test/frame_difference_motion_salience_top_tb.sv @@
// Self-checking testbench for the frame-difference motion salience block.
`timescale 1ns / 1ps

module frame_difference_motion_salience_top_tb;
   import fdms_pkg::*;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } rgb_type;

   typedef struct {
      rgb_type pix;
      logic    frame_end;
   } pixel_beat_type;

   typedef struct {
      logic [SAL_W-1:0]   salience;
      logic [SHADE_W-1:0] red;
      logic [SHADE_W-1:0] green;
      logic               last;
   } salience_type;

   localparam int SCENE_PIXELS  = 64;
   localparam int RANDOM_ITEMS  = 1550;
   localparam int CALM_FROM     = 1350;
   localparam int LATENCY       = 3;
   localparam int MAX_PRINTS    = 100;
   localparam int DIST_PER_RED  = 10;
   localparam int MAX_FRAME_LEN = 40;
   localparam int RESET_CYCLES  = 12;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   logic                  req_tlast   = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_wr_en   = 1'b0;
   logic [GAP_W-1:0]      csr_wr_data = '0;

   frame_difference_motion_salience_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #4_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   // predictor state
   rgb_type          frame_ring [SLOTS*FRAME_PIXELS];
   int unsigned      ring_pos;
   int unsigned      ring_slot;
   int unsigned      frames_held;
   logic [GAP_W-1:0] gap_shadow;

   pixel_beat_type pixel_queue [$];
   salience_type   salience_queue [$];
   pixel_beat_type next_beat;
   rgb_type        scene [SCENE_PIXELS];

   int   fail_count    = 0;
   int   random_items  = 0;
   int   req_idle_left = 0;
   int   rsp_idle_left = 0;
   logic req_took      = 1'b0;
   logic calm          = 1'b0;

   function automatic int unsigned sq_diff(input logic [CHAN_W-1:0] a,
                                           input logic [CHAN_W-1:0] b);
      int unsigned d;
      d = (a > b) ? a - b : b - a;
      return d * d;
   endfunction

   function automatic void predict_salience(input pixel_beat_type beat);
      int unsigned  eff_gap;
      int unsigned  held;
      int unsigned  ref_slot;
      int unsigned  distance;
      rgb_type      ref_pix;
      salience_type want;
      eff_gap  = (gap_shadow > MAX_GAP) ? MAX_GAP : gap_shadow;
      held     = (frames_held > eff_gap) ? eff_gap : frames_held;
      ref_slot = (ring_slot + SLOTS - held) % SLOTS;
      // no complete frame yet: the pixel is its own reference
      ref_pix  = (held == 0) ? beat.pix : frame_ring[ref_slot*FRAME_PIXELS + ring_pos];
      distance = sq_diff(ref_pix.red, beat.pix.red) + sq_diff(ref_pix.green, beat.pix.green)
               + sq_diff(ref_pix.blue, beat.pix.blue);
      want.salience = (distance > SAL_MAX) ? SAL_MAX : SAL_W'(distance);
      want.red      = (distance / DIST_PER_RED > SHADE_MAX) ? SHADE_MAX
                                                            : SHADE_W'(distance / DIST_PER_RED);
      want.green    = (distance > SHADE_MAX) ? SHADE_MAX : SHADE_W'(distance);
      want.last     = beat.frame_end;
      salience_queue.insert(salience_queue.size(), want);

      frame_ring[ring_slot*FRAME_PIXELS + ring_pos] = beat.pix;
      if (beat.frame_end) begin
         ring_pos    = 0;
         ring_slot   = (ring_slot + 1) % SLOTS;
         frames_held = (held < eff_gap) ? held + 1 : held;
      end else begin
         // an overlong frame wraps and keeps writing the same slot
         ring_pos    = (ring_pos + 1 == FRAME_PIXELS) ? 0 : ring_pos + 1;
         frames_held = held;
      end
   endfunction

   // sample everything at the rising edge
   always @(posedge clock) begin
      salience_type want;
      req_took = 1'b0;
      if (reset) begin
         ring_pos    = 0;
         ring_slot   = 0;
         frames_held = 0;
         gap_shadow  = GAP_RESET;
      end else begin
         if (csr_wr_en) begin
            gap_shadow  = csr_wr_data;
            frames_held = 0;
         end
         if (req_tvalid && req_tready) begin
            req_took = 1'b1;
            next_beat.pix       = {req_tdata[7:0], req_tdata[15:8], req_tdata[23:16]};
            next_beat.frame_end = req_tlast;
            predict_salience(next_beat);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (salience_queue.size() == 0) begin
               fail_count++;
               if (fail_count <= MAX_PRINTS)
                  $display("%0t: result beat with nothing pending, actual data %h last %b",
                           $time, rsp_tdata, rsp_tlast);
            end else begin
               want = salience_queue[0];
               salience_queue.delete(0);
               if (rsp_tdata[11:0] !== want.salience || rsp_tdata[19:12] !== want.red ||
                   rsp_tdata[27:20] !== want.green || rsp_tlast !== want.last) begin
                  fail_count++;
                  // quiet after the first few screenfuls
                  if (fail_count <= MAX_PRINTS)
                     $display({"%0t: salience/red/green/last expected %0d/%0d/%0d/%b",
                               " actual %0d/%0d/%0d/%b"},
                              $time, want.salience, want.red, want.green, want.last,
                              rsp_tdata[11:0], rsp_tdata[19:12], rsp_tdata[27:20], rsp_tlast);
               end
            end
         end
      end
   end

   // pixel driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!(req_tvalid && !req_took)) begin
         if (req_idle_left > 0) begin
            req_idle_left--;
            req_tvalid <= 1'b0;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            req_idle_left = $urandom_range(0, 14);
            req_tvalid <= 1'b0;
         end else if (pixel_queue.size() > 0) begin
            next_beat = pixel_queue[0];
            pixel_queue.delete(0);
            req_tdata  <= {next_beat.pix.blue, next_beat.pix.green, next_beat.pix.red};
            req_tlast  <= next_beat.frame_end;
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result sink backpressure
   always @(negedge clock) begin
      if (rsp_idle_left > 0) begin
         rsp_idle_left--;
         rsp_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         rsp_idle_left = $urandom_range(0, 14);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic queue_pixel(input int r, input int g, input int b, input logic last);
      pixel_beat_type beat;
      beat.pix       = {CHAN_W'(r), CHAN_W'(g), CHAN_W'(b)};
      beat.frame_end = last;
      pixel_queue.insert(pixel_queue.size(), beat);
   endtask

   function automatic logic [CHAN_W-1:0] jitter(input int base, input int spread);
      int v;
      v = base + int'($urandom_range(0, 2 * spread)) - spread;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return CHAN_W'(v);
   endfunction

   task automatic queue_frame(input int len);
      int      spread;
      rgb_type base;
      case ($urandom_range(0, 4))
         0: spread = 0;
         1: spread = 2;
         2: spread = 10;
         3: spread = 30;
         default: spread = 120;
      endcase
      for (int i = 0; i < len; i++) begin
         base = scene[i % SCENE_PIXELS];
         if ($urandom_range(0, 15) == 0)
            queue_pixel($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                        i == len - 1);
         else
            queue_pixel(jitter(base.red, spread), jitter(base.green, spread),
                        jitter(base.blue, spread), i == len - 1);
      end
   endtask

   task automatic wait_drained();
      while (pixel_queue.size() > 0 || salience_queue.size() > 0 || req_tvalid)
         @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   // one gap setting; all frames share one length so that every reference
   // position has been written
   task automatic run_phase(input int gap, input int len, input int frames);
      wait_drained();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= GAP_W'(gap);
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      for (int i = 0; i < SCENE_PIXELS; i++)
         scene[i] = rgb_type'(PIX_W'($urandom_range(0, 24'hFFFFFF)));
      for (int f = 0; f < frames; f++)
         queue_frame(len);
      random_items += frames * len;
   endtask

   initial begin
      int phase;
      int gap_pick;
      int len;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // gap at its reset value: frames one to three all look back at frame zero
      queue_pixel(0, 0, 0, 1'b0);
      queue_pixel(255, 255, 255, 1'b0);
      queue_pixel(0, 0, 0, 1'b0);
      queue_pixel(0, 0, 0, 1'b1);
      queue_pixel(255, 255, 255, 1'b0);   // full-scale distance
      queue_pixel(0, 0, 0, 1'b0);
      queue_pixel(50, 7, 0, 1'b0);        // just under the salience limit
      queue_pixel(50, 5, 5, 1'b1);        // exactly at it
      queue_pixel(48, 16, 0, 1'b0);       // red shade just saturates
      queue_pixel(255, 255, 255, 1'b0);   // no motion
      queue_pixel(16, 0, 0, 1'b0);        // green shade just past saturation
      queue_pixel(0, 0, 1, 1'b1);
      queue_pixel(3, 3, 0, 1'b0);
      queue_pixel(200, 0, 100, 1'b0);
      queue_pixel(9, 0, 0, 1'b0);
      queue_pixel(13, 9, 2, 1'b1);        // green shade one below saturation

      phase = 0;
      while (random_items < RANDOM_ITEMS) begin
         case (phase)
            0: gap_pick = 0;
            1: gap_pick = MAX_GAP;
            2: gap_pick = $urandom_range(1, MAX_GAP);
            default: gap_pick = $urandom_range(0, MAX_GAP);
         endcase
         len = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, MAX_FRAME_LEN);
         calm = (random_items >= CALM_FROM);
         run_phase(gap_pick, len, gap_pick + $urandom_range(2, 5));
         phase++;
      end
      wait_drained();
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

@@ files.f @@
hdl/fdms_pkg.sv
hdl/fdms_ram.sv
hdl/frame_difference_motion_salience_top.sv
hdl/fdms_checker.sv
test/frame_difference_motion_salience_top_tb.sv
